// ----- sv/keyed_count_and_sum_table_macros.svh -----
// Assertion macros shared by the checker
`ifndef KEYED_COUNT_AND_SUM_TABLE_MACROS_SVH
`define KEYED_COUNT_AND_SUM_TABLE_MACROS_SVH

// Same-cycle implication, disabled in reset
`define KCST_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset
`define KCST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked also across reset
`define KCST_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/kcst_pkg.sv -----
`default_nettype none
package kcst_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int KEY_BYTES     = 128;
    localparam int QUEUE_DEPTH   = 2;

    localparam int EW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int UW  = $clog2(TABLE_ENTRIES + 1);
    localparam int PW  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int LW  = $clog2(KEY_BYTES + 1);
    localparam int KAW = $clog2(TABLE_ENTRIES * KEY_BYTES);
    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MODE_KEY   = 2'd0;
    localparam logic [1:0] MODE_CLOSE = 2'd1;
    localparam logic [1:0] MODE_COUNT = 2'd2;
    localparam logic [1:0] MODE_CHAR  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    typedef enum logic [1:0] {
        OP_KEY,
        OP_CLOSE,
        OP_READ_COUNT,
        OP_READ_CHAR
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  key_char;
        logic [15:0] amount;
        logic [7:0]  entry_index;
        logic [6:0]  char_position;
    } item_t;

    typedef struct packed {
        logic [15:0] record_count;
        logic [31:0] amount_total;
        logic [7:0]  read_char;
        logic        entry_valid;
        logic [8:0]  entries_used;
        logic [1:0]  status;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_LEN,
        S_CMP,
        S_CHK,
        S_UPD,
        S_COPY,
        S_CPWR,
        S_RDW,
        S_DONE
    } state_t;

    function automatic op_t decode_mode(input logic [1:0] mode);
        op_t op;
        case (mode)
            MODE_KEY:   op = OP_KEY;
            MODE_CLOSE: op = OP_CLOSE;
            MODE_COUNT: op = OP_READ_COUNT;
            MODE_CHAR:  op = OP_READ_CHAR;
            default:    op = OP_KEY;
        endcase
        return op;
    endfunction

    function automatic logic [KAW-1:0] key_addr(input logic [EW-1:0] ent,
                                                input logic [PW-1:0] pos);
        return KAW'(ent) * KAW'(KEY_BYTES) + KAW'(pos);
    endfunction

endpackage
`default_nettype wire

// ----- sv/kcst_ram.sv -----
`default_nettype none
module kcst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word registered
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- sv/kcst_front.sv -----
`default_nettype none
module kcst_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_mode,
    input  wire logic [7:0]          s_key_char,
    input  wire logic [15:0]         s_amount,
    input  wire logic [7:0]          s_entry_index,
    input  wire logic [6:0]          s_char_position,
    output logic                     q_valid,
    output kcst_pkg::item_t          q_item,
    input  wire logic                q_pop
);

    kcst_pkg::item_t               mem_reg [kcst_pkg::QUEUE_DEPTH];
    logic [kcst_pkg::QPW-1:0]      wp_reg, wp_next;
    logic [kcst_pkg::QPW-1:0]      rp_reg, rp_next;
    logic [kcst_pkg::QCW-1:0]      cnt_reg, cnt_next;
    kcst_pkg::item_t               in_item;
    logic                          push;

    // Classify the incoming item
    always_comb begin
        in_item.op            = kcst_pkg::decode_mode(s_mode);
        in_item.key_char      = s_key_char;
        in_item.amount        = s_amount;
        in_item.entry_index   = s_entry_index;
        in_item.char_position = s_char_position;
    end

    assign s_ready = (cnt_reg != kcst_pkg::QCW'(kcst_pkg::QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem_reg[rp_reg];

    // Advance pointers and fill count
    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wp_next = (wp_reg == kcst_pkg::QPW'(kcst_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (q_pop) begin
            rp_next = (rp_reg == kcst_pkg::QPW'(kcst_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && q_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Hold queued items
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// ----- sv/kcst_engine.sv -----
`default_nettype none
module kcst_engine (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  wire kcst_pkg::item_t   q_item,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output kcst_pkg::result_t      m_result
);

    localparam int EW  = kcst_pkg::EW;
    localparam int UW  = kcst_pkg::UW;
    localparam int PW  = kcst_pkg::PW;
    localparam int LW  = kcst_pkg::LW;
    localparam int KAW = kcst_pkg::KAW;

    kcst_pkg::state_t  state_reg, state_next;
    kcst_pkg::item_t   item_reg, item_next;
    kcst_pkg::result_t res_reg, res_next;
    kcst_pkg::result_t out_reg, out_next;
    logic              m_valid_reg, m_valid_next;
    logic [UW-1:0]     e_reg, e_next;
    logic [UW-1:0]     used_reg, used_next;
    logic [LW-1:0]     pos_reg, pos_next;
    logic [LW-1:0]     plen_reg, plen_next;
    logic              ovf_reg, ovf_next;

    // Memory ports
    logic           pk_we;
    logic [PW-1:0]  pk_waddr, pk_raddr;
    logic [7:0]     pk_wdata, pk_rdata;
    logic           sk_we;
    logic [KAW-1:0] sk_waddr, sk_raddr;
    logic [7:0]     sk_wdata, sk_rdata;
    logic           ent_we;
    logic [EW-1:0]  ent_waddr, ent_raddr;
    logic [LW-1:0]  ln_wdata, ln_rdata;
    logic [15:0]    ct_wdata, ct_rdata;
    logic [31:0]    tt_wdata, tt_rdata;

    logic           key_room, table_room, search_end, idx_ok, pos_ok;
    logic [15:0]    cnt_sat;
    logic [32:0]    tot_sum;
    logic [31:0]    tot_sat;

    kcst_ram #(.WIDTH(8), .DEPTH(kcst_pkg::KEY_BYTES)) u_pend (
        .clk(aclk), .we(pk_we), .waddr(pk_waddr), .wdata(pk_wdata),
        .raddr(pk_raddr), .rdata(pk_rdata));
    kcst_ram #(.WIDTH(8), .DEPTH(kcst_pkg::TABLE_ENTRIES * kcst_pkg::KEY_BYTES)) u_keys (
        .clk(aclk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
        .raddr(sk_raddr), .rdata(sk_rdata));
    kcst_ram #(.WIDTH(LW), .DEPTH(kcst_pkg::TABLE_ENTRIES)) u_len (
        .clk(aclk), .we(ent_we), .waddr(ent_waddr), .wdata(ln_wdata),
        .raddr(ent_raddr), .rdata(ln_rdata));
    kcst_ram #(.WIDTH(16), .DEPTH(kcst_pkg::TABLE_ENTRIES)) u_cnt (
        .clk(aclk), .we(ent_we), .waddr(ent_waddr), .wdata(ct_wdata),
        .raddr(ent_raddr), .rdata(ct_rdata));
    kcst_ram #(.WIDTH(32), .DEPTH(kcst_pkg::TABLE_ENTRIES)) u_tot (
        .clk(aclk), .we(ent_we), .waddr(ent_waddr), .wdata(tt_wdata),
        .raddr(ent_raddr), .rdata(tt_rdata));

    // Conditions and saturating updates
    assign key_room   = (plen_reg < LW'(kcst_pkg::KEY_BYTES));
    assign table_room = (used_reg < UW'(kcst_pkg::TABLE_ENTRIES));
    assign search_end = (e_reg == used_reg);
    assign idx_ok     = (int'(q_item.entry_index) < int'(used_reg));
    assign pos_ok     = (item_reg.op == kcst_pkg::OP_READ_CHAR)
                     && (int'(item_reg.char_position) < int'(ln_rdata))
                     && (int'(item_reg.char_position) < kcst_pkg::KEY_BYTES);
    assign cnt_sat    = (ct_rdata == 16'hFFFF) ? ct_rdata : ct_rdata + 16'd1;
    assign tot_sum    = {1'b0, tt_rdata} + 33'(item_reg.amount);
    assign tot_sat    = tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];

    assign q_pop    = (state_reg == kcst_pkg::S_IDLE) && q_valid;
    assign m_valid  = m_valid_reg;
    assign m_result = out_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            kcst_pkg::S_IDLE: begin
                if (q_valid) begin
                    case (q_item.op)
                        kcst_pkg::OP_CLOSE: state_next = kcst_pkg::S_SRCH;
                        kcst_pkg::OP_READ_COUNT,
                        kcst_pkg::OP_READ_CHAR:
                            state_next = idx_ok ? kcst_pkg::S_RDW : kcst_pkg::S_DONE;
                        default: state_next = kcst_pkg::S_DONE;
                    endcase
                end
            end
            kcst_pkg::S_SRCH: begin
                if (!search_end) begin
                    state_next = kcst_pkg::S_LEN;
                end else if (table_room) begin
                    state_next = kcst_pkg::S_COPY;
                end else begin
                    state_next = kcst_pkg::S_DONE;
                end
            end
            kcst_pkg::S_LEN:
                state_next = (ln_rdata == plen_reg) ? kcst_pkg::S_CMP : kcst_pkg::S_SRCH;
            kcst_pkg::S_CMP:
                state_next = (pos_reg == plen_reg) ? kcst_pkg::S_UPD : kcst_pkg::S_CHK;
            kcst_pkg::S_CHK:
                state_next = (sk_rdata == pk_rdata) ? kcst_pkg::S_CMP : kcst_pkg::S_SRCH;
            kcst_pkg::S_UPD:  state_next = kcst_pkg::S_DONE;
            kcst_pkg::S_COPY:
                state_next = (pos_reg == plen_reg) ? kcst_pkg::S_DONE : kcst_pkg::S_CPWR;
            kcst_pkg::S_CPWR: state_next = kcst_pkg::S_COPY;
            kcst_pkg::S_RDW:  state_next = kcst_pkg::S_DONE;
            kcst_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = kcst_pkg::S_IDLE;
                end
            end
            default: state_next = kcst_pkg::S_IDLE;
        endcase
    end

    // Datapath registers
    always_comb begin
        item_next    = item_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        e_next       = e_reg;
        pos_next     = pos_reg;
        plen_next    = plen_reg;
        used_next    = used_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            kcst_pkg::S_IDLE: begin
                if (q_valid) begin
                    item_next = q_item;
                    res_next  = '0;
                    e_next    = '0;
                    case (q_item.op)
                        kcst_pkg::OP_KEY: begin
                            if (key_room) begin
                                plen_next = plen_reg + 1'b1;
                            end else begin
                                res_next.status = kcst_pkg::ST_TRUNC;
                            end
                        end
                        kcst_pkg::OP_READ_COUNT,
                        kcst_pkg::OP_READ_CHAR:
                            res_next.status = ovf_reg ? kcst_pkg::ST_FULL : kcst_pkg::ST_OK;
                        default: ;
                    endcase
                end
            end
            kcst_pkg::S_SRCH: begin
                pos_next = '0;
                if (search_end && !table_room) begin
                    ovf_next        = 1'b1;
                    plen_next       = '0;
                    res_next.status = kcst_pkg::ST_FULL;
                end
            end
            kcst_pkg::S_LEN: begin
                if (ln_rdata != plen_reg) begin
                    e_next = e_reg + 1'b1;
                end
            end
            kcst_pkg::S_CHK: begin
                if (sk_rdata == pk_rdata) begin
                    pos_next = pos_reg + 1'b1;
                end else begin
                    pos_next = '0;
                    e_next   = e_reg + 1'b1;
                end
            end
            kcst_pkg::S_UPD: begin
                plen_next             = '0;
                res_next.record_count = cnt_sat;
                res_next.amount_total = tot_sat;
                res_next.entry_valid  = 1'b1;
            end
            kcst_pkg::S_COPY: begin
                if (pos_reg == plen_reg) begin
                    plen_next             = '0;
                    used_next             = used_reg + 1'b1;
                    res_next.record_count = 16'd1;
                    res_next.amount_total = 32'(item_reg.amount);
                    res_next.entry_valid  = 1'b1;
                end
            end
            kcst_pkg::S_CPWR: pos_next = pos_reg + 1'b1;
            kcst_pkg::S_RDW: begin
                res_next.record_count = ct_rdata;
                res_next.amount_total = tt_rdata;
                res_next.entry_valid  = 1'b1;
                res_next.read_char    = pos_ok ? sk_rdata : 8'd0;
            end
            kcst_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    out_next              = res_reg;
                    out_next.entries_used = 9'(used_reg);
                end
            end
            default: ;
        endcase
    end

    // Memory controls
    always_comb begin
        pk_we     = 1'b0;
        pk_waddr  = plen_reg[PW-1:0];
        pk_wdata  = q_item.key_char;
        pk_raddr  = pos_reg[PW-1:0];
        sk_we     = 1'b0;
        sk_waddr  = kcst_pkg::key_addr(used_reg[EW-1:0], pos_reg[PW-1:0]);
        sk_wdata  = pk_rdata;
        sk_raddr  = kcst_pkg::key_addr(e_reg[EW-1:0], pos_reg[PW-1:0]);
        ent_we    = 1'b0;
        ent_waddr = e_reg[EW-1:0];
        ent_raddr = e_reg[EW-1:0];
        ln_wdata  = plen_reg;
        ct_wdata  = cnt_sat;
        tt_wdata  = tot_sat;
        case (state_reg)
            kcst_pkg::S_IDLE: begin
                pk_we     = q_valid && (q_item.op == kcst_pkg::OP_KEY) && key_room;
                ent_raddr = EW'(q_item.entry_index);
                sk_raddr  = kcst_pkg::key_addr(EW'(q_item.entry_index),
                                               PW'(q_item.char_position));
            end
            kcst_pkg::S_UPD: ent_we = 1'b1;
            kcst_pkg::S_COPY: begin
                if (pos_reg == plen_reg) begin
                    ent_we    = 1'b1;
                    ent_waddr = used_reg[EW-1:0];
                    ct_wdata  = 16'd1;
                    tt_wdata  = 32'(item_reg.amount);
                end
            end
            kcst_pkg::S_CPWR: sk_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= kcst_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
            plen_reg    <= '0;
            used_reg    <= '0;
            ovf_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            plen_reg    <= plen_next;
            used_reg    <= used_next;
            ovf_reg     <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        e_reg    <= e_next;
        pos_reg  <= pos_next;
    end

endmodule
`default_nettype wire

// ----- sv/keyed_count_and_sum_table.sv -----
// Group-by table: key bytes arrive one per item, a close item carries the
// record amount and looks the key up among stored keys in order of first
// appearance, bumping count and total or taking the next free entry. Items
// go through a two-deep input queue into an engine that handles one item at
// a time, and each result waits in an output register. A close item walks
// the table one entry at a time: it checks each entry's length, compares a
// key of equal length byte by byte, and copies the pending key byte by
// byte into a new entry when no key matches; the walk runs over the length,
// key and pending-key memories. The table memories come up undefined;
// nothing is read above the used-entry count.
`default_nettype none
module keyed_count_and_sum_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [7:0]  s_key_char,
    input  wire logic [15:0] s_amount,
    input  wire logic [7:0]  s_entry_index,
    input  wire logic [6:0]  s_char_position,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_record_count,
    output logic [31:0]      m_amount_total,
    output logic [7:0]       m_read_char,
    output logic             m_entry_valid,
    output logic [8:0]       m_entries_used,
    output logic [1:0]       m_status
);

    logic              q_valid;
    logic              q_pop;
    kcst_pkg::item_t   q_item;
    kcst_pkg::result_t result;

    kcst_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_key_char      (s_key_char),
        .s_amount        (s_amount),
        .s_entry_index   (s_entry_index),
        .s_char_position (s_char_position),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop)
    );

    kcst_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result)
    );

    assign m_record_count = result.record_count;
    assign m_amount_total = result.amount_total;
    assign m_read_char    = result.read_char;
    assign m_entry_valid  = result.entry_valid;
    assign m_entries_used = result.entries_used;
    assign m_status       = result.status;

endmodule
`default_nettype wire

// ----- sv/kcst_checker.sv -----
`default_nettype none
`include "keyed_count_and_sum_table_macros.svh"
module kcst_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_record_count,
    input wire logic [31:0] m_amount_total,
    input wire logic [7:0]  m_read_char,
    input wire logic        m_entry_valid,
    input wire logic [8:0]  m_entries_used,
    input wire logic [1:0]  m_status
);

    // A stalled item stays on the result side
    `KCST_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)

    // No item leaves in the cycle after reset
    `KCST_ASSERT_ALWAYS_NEXT(a_reset_quiet, aclk, !aresetn, !m_valid)

    // A truncated key byte never reports an entry
    `KCST_ASSERT_IMPLY(a_trunc_empty, aclk, aresetn, m_valid && (m_status == kcst_pkg::ST_TRUNC), !m_entry_valid && (m_record_count == 16'd0) && (m_amount_total == 32'd0) && (m_read_char == 8'd0))

    // An in-use entry always holds at least one record
    `KCST_ASSERT_IMPLY(a_valid_count, aclk, aresetn, m_valid && m_entry_valid, (m_record_count != 16'd0) && (m_entries_used != 9'd0))

endmodule

bind keyed_count_and_sum_table kcst_checker u_kcst_checker (.*);
`default_nettype wire
